FILE: hw/rtl/sab_pkg.sv
// Package with the shared types, constants and helpers of the sprite alpha blitter.
`timescale 1ns / 1ps

package sab_pkg;

    localparam int BOARD_COLS = 256;
    localparam int BOARD_ROWS = 128;
    localparam int SPRITE_MAX = 64;

    localparam int CELLS      = BOARD_ROWS * BOARD_COLS;
    localparam int EVEN_DEPTH = (CELLS + 1) / 2;
    localparam int ODD_DEPTH  = CELLS / 2;
    localparam int BA_W       = $clog2(EVEN_DEPTH);
    localparam int GEO_W      = ($clog2(BOARD_COLS) > 11 ? $clog2(BOARD_COLS) : 11) + 2;
    localparam int LIN_W      = $clog2(CELLS) + 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [7:0] ALPHA_MAX = 8'd255;

    typedef logic signed [GEO_W-1:0] t_geo;
    typedef logic signed [LIN_W-1:0] t_lin;

    typedef enum logic [2:0] {
        REG_SPRITE_WIDTH    = 3'd0,
        REG_SPRITE_HEIGHT   = 3'd1,
        REG_CENTER_COL      = 3'd2,
        REG_CENTER_ROW      = 3'd3,
        REG_QUARTER_TURNS   = 3'd4,
        REG_MIRROR_BITS     = 3'd5,
        REG_ORIGIN_HALF_COL = 3'd6,
        REG_ORIGIN_ROW      = 3'd7
    } t_reg_idx;

    typedef enum logic [0:0] {
        ACT_BLIT = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef struct packed {
        logic [6:0]        sprite_width;
        logic [6:0]        sprite_height;
        logic [5:0]        center_col;
        logic [5:0]        center_row;
        logic [1:0]        quarter_turns;
        logic [1:0]        mirror_bits;
        logic signed [9:0] origin_half_col;
        logic signed [8:0] origin_row;
    } t_cfg;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? ALPHA_MAX : s[7:0];
    endfunction

endpackage

FILE: hw/rtl/sab_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
`timescale 1ns / 1ps

interface sab_pix_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [5:0] pixel_row;
    logic [5:0] pixel_col;
    logic [7:0] pixel_alpha;
    logic [6:0] read_row;
    logic [7:0] read_col;

    modport source (output valid, action, pixel_row, pixel_col, pixel_alpha, read_row,
                    read_col, input ready);
    modport sink   (input valid, action, pixel_row, pixel_col, pixel_alpha, read_row,
                    read_col, output ready);
endinterface

interface sab_res_if;
    logic               valid;
    logic               ready;
    logic [7:0]         cell_value;
    logic               left_written;
    logic               right_written;
    logic signed [9:0]  target_row;
    logic signed [10:0] target_col;

    modport source (output valid, cell_value, left_written, right_written, target_row,
                    target_col, input ready);
    modport sink   (input valid, cell_value, left_written, right_written, target_row,
                    target_col, output ready);
endinterface

interface sab_cfg_if;
    logic                                valid;
    logic                                ready;
    sab_pkg::t_reg_idx                   index;
    logic [sab_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sprite_alpha_blitter.sv
// Top level of the sprite alpha blitter: configuration, board memories and sequencer.
`timescale 1ns / 1ps

// Each item passes through accept and geometry, memory address and read, and add and write
// back, each in its own state, as the two board memory banks are read into registers; write
// back waits while the result register is full and not taken. The next item is accepted as
// soon as the previous result sits in the output register. After reset the block clears the
// board and accepts no beat until the clear is done; configuration writes are taken at all times.
module sprite_alpha_blitter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sab_pix_if.sink   i_pix,
    sab_res_if.source o_res,
    sab_cfg_if.sink   i_cfg
);
    import sab_pkg::*;

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_ADDR = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_cfg   r_cfg;

    logic [BA_W-1:0] r_clr;
    logic            r_act;
    logic [7:0]      r_alpha;
    t_geo            r_row, r_col;
    logic            r_left_in, r_right_in, r_lodd;
    logic [BA_W-1:0] r_ea, r_oa;

    logic [7:0] even_mem [EVEN_DEPTH];
    logic [7:0] odd_mem  [ODD_DEPTH];
    logic [7:0] r_even_q, r_odd_q;

    logic               r_out_valid;
    logic [7:0]         r_out_value;
    logic               r_out_lw, r_out_rw;
    logic signed [9:0]  r_out_row;
    logic signed [10:0] r_out_col;

    t_geo geo_row, geo_col, col1;
    t_lin lin, half;
    logic row_ok, left_in, right_in;
    logic [BA_W-1:0] ea, oa;

    logic       upd_fire, blit_on, wr_left, wr_right;
    logic [7:0] left_q, right_q, sat_l, sat_r;
    logic       we_e, we_o;
    logic [7:0] wd_e, wd_o;
    logic [BA_W-1:0] wa_e, wa_o;

    sab_geom u_geom (
        .i_cfg       (r_cfg),
        .i_pixel_row (i_pix.pixel_row),
        .i_pixel_col (i_pix.pixel_col),
        .o_row       (geo_row),
        .o_col       (geo_col)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sprite_width: 7'd1, sprite_height: 7'd1, default: '0};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SPRITE_WIDTH:    r_cfg.sprite_width    <= i_cfg.data[6:0];
                REG_SPRITE_HEIGHT:   r_cfg.sprite_height   <= i_cfg.data[6:0];
                REG_CENTER_COL:      r_cfg.center_col      <= i_cfg.data[5:0];
                REG_CENTER_ROW:      r_cfg.center_row      <= i_cfg.data[5:0];
                REG_QUARTER_TURNS:   r_cfg.quarter_turns   <= i_cfg.data[1:0];
                REG_MIRROR_BITS:     r_cfg.mirror_bits     <= i_cfg.data[1:0];
                REG_ORIGIN_HALF_COL: r_cfg.origin_half_col <= $signed(i_cfg.data[9:0]);
                REG_ORIGIN_ROW:      r_cfg.origin_row      <= $signed(i_cfg.data[8:0]);
            endcase
        end
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign upd_fire    = (r_state == S_UPD) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr == BA_W'(EVEN_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (i_pix.valid) n_state = S_ADDR;
            S_ADDR: n_state = S_UPD;
            S_UPD:  if (upd_fire) n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + BA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_act   <= i_pix.action;
            r_alpha <= i_pix.pixel_alpha;
            if (i_pix.action == ACT_READ) begin
                r_row <= t_geo'(i_pix.read_row);
                r_col <= t_geo'(i_pix.read_col);
            end else begin
                r_row <= geo_row;
                r_col <= geo_col;
            end
        end
    end

    always_comb begin
        col1     = r_col + t_geo'(1);
        row_ok   = (r_row >= t_geo'(0)) && (r_row < t_geo'(BOARD_ROWS));
        left_in  = row_ok && (r_col >= t_geo'(0)) && (r_col < t_geo'(BOARD_COLS));
        right_in = row_ok && (col1 >= t_geo'(0)) && (col1 < t_geo'(BOARD_COLS));
        lin      = t_lin'(r_row) * t_lin'(BOARD_COLS) + t_lin'(r_col);
        half     = lin >>> 1;
        ea       = BA_W'(half + t_lin'(lin[0]));
        oa       = BA_W'(half);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_left_in  <= left_in;
            r_right_in <= right_in;
            r_lodd     <= lin[0];
            r_ea       <= ea;
            r_oa       <= oa;
            r_even_q   <= even_mem[ea];
            r_odd_q    <= odd_mem[oa];
        end
    end

    always_comb begin
        left_q   = r_lodd ? r_odd_q : r_even_q;
        right_q  = r_lodd ? r_even_q : r_odd_q;
        sat_l    = sat_add(left_q, r_alpha);
        sat_r    = sat_add(right_q, r_alpha);
        blit_on  = (r_act == ACT_BLIT) && (r_alpha != 8'd0);
        wr_left  = blit_on && r_left_in;
        wr_right = blit_on && r_right_in;
        if (r_state == S_CLR) begin
            we_e = 1'b1;
            we_o = (32'(r_clr) < ODD_DEPTH);
            wd_e = 8'd0;
            wd_o = 8'd0;
            wa_e = r_clr;
            wa_o = r_clr;
        end else begin
            we_e = upd_fire && (r_lodd ? wr_right : wr_left);
            we_o = upd_fire && (r_lodd ? wr_left : wr_right);
            wd_e = r_lodd ? sat_r : sat_l;
            wd_o = r_lodd ? sat_l : sat_r;
            wa_e = r_ea;
            wa_o = r_oa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_e) begin
            even_mem[wa_e] <= wd_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_o) begin
            odd_mem[wa_o] <= wd_o;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_lw <= wr_left;
            r_out_rw <= wr_right;
            if (!r_left_in) begin
                r_out_value <= 8'd0;
            end else if (wr_left) begin
                r_out_value <= sat_l;
            end else begin
                r_out_value <= left_q;
            end
            if (r_act == ACT_READ) begin
                r_out_row <= '0;
                r_out_col <= '0;
            end else begin
                r_out_row <= r_row[9:0];
                r_out_col <= r_col[10:0];
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.cell_value    = r_out_value;
    assign o_res.left_written  = r_out_lw;
    assign o_res.right_written = r_out_rw;
    assign o_res.target_row    = r_out_row;
    assign o_res.target_col    = r_out_col;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_pix.ready)
        else $error("Pixel beat accepted during board clear.");

    a_accept_to_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (r_state == S_ADDR))
        else $error("Accepted beat did not proceed to the address cycle.");

    a_update_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_fire |=> r_out_valid)
        else $error("Write-back finished without a result.");

    a_no_write_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && r_out_valid && !o_res.ready) |-> !(we_e || we_o))
        else $error("Board written while the result register is blocked.");

endmodule

FILE: hw/rtl/sab_geom.sv
// Mirror and quarter-turn geometry that maps a sprite pixel to its board position.
`timescale 1ns / 1ps

module sab_geom (
    input  sab_pkg::t_cfg i_cfg,
    input  logic [5:0]    i_pixel_row,
    input  logic [5:0]    i_pixel_col,
    output sab_pkg::t_geo o_row,
    output sab_pkg::t_geo o_col
);
    import sab_pkg::*;

    t_geo pr, pc, w, h, cx, cy, ex, ey, ox2, oy, fr, fc;

    always_comb begin
        pr  = t_geo'(i_pixel_row);
        pc  = t_geo'(i_pixel_col);
        w   = t_geo'(i_cfg.sprite_width);
        h   = t_geo'(i_cfg.sprite_height);
        cx  = t_geo'(i_cfg.center_col);
        cy  = t_geo'(i_cfg.center_row);
        ex  = t_geo'(!i_cfg.center_col[0]);
        ey  = t_geo'(!i_cfg.center_row[0]);
        ox2 = t_geo'(i_cfg.origin_half_col);
        oy  = t_geo'(i_cfg.origin_row);
        fr  = i_cfg.mirror_bits[1] ? h - t_geo'(1) - pr : pr;
        fc  = i_cfg.mirror_bits[0] ? w - t_geo'(1) - pc : pc;
        case (i_cfg.quarter_turns)
            2'd0: begin
                o_row = oy - cy + fr;
                o_col = ox2 + ((fc - cx) <<< 1);
            end
            2'd1: begin
                o_row = oy - cx + fc;
                o_col = ox2 + ((cy - fr - ey) <<< 1);
            end
            2'd2: begin
                o_row = oy + cy - fr - ey;
                o_col = ox2 + ((cx - fc - ex) <<< 1);
            end
            default: begin
                o_row = oy + cx - fc - ex;
                o_col = ox2 + ((fr - cy) <<< 1);
            end
        endcase
    end

endmodule
